// ===== rtl/bil_pkg.sv =====
// Package for the bounded indexed list: operation codes, controller states,
// command and status structs, and default sizes. No dependencies.
`timescale 1ns / 1ps

package bil_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int ITEM_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_READ    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_REPLACE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_PUT,
    S_RDWAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_step;
    logic read_issue;
    logic read_capture;
    logic write_val;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ins_ok;
    logic rem_ok;
    logic rd_ok;
    logic rep_ok;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/bil_req_if.sv =====
// Request channel of the bounded indexed list: valid, ready and payload.
// Depends on bil_pkg for field widths.
`timescale 1ns / 1ps

interface bil_req_if;
  logic                                valid;
  logic                                ready;
  logic [bil_pkg::OP_W-1:0]            op;
  logic [bil_pkg::POS_W-1:0]           position;
  logic signed [bil_pkg::ITEM_W-1:0]   item_value;

  modport source (output valid, output op, output position, output item_value, input ready);
  modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

// ===== rtl/bil_rsp_if.sv =====
// Response channel of the bounded indexed list: valid, ready and payload.
// Depends on bil_pkg for field widths.
`timescale 1ns / 1ps

interface bil_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [bil_pkg::ITEM_W-1:0]   read_data;
  logic [bil_pkg::POS_W-1:0]           found_position;
  logic [bil_pkg::POS_W-1:0]           entry_count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, output ok, output read_data, output found_position,
                  output entry_count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input read_data, input found_position,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/bil_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bil_ctrl.sv =====
// Controller of the bounded indexed list: sequences each request through the
// datapath by commands. Depends on bil_pkg.
`timescale 1ns / 1ps

module bil_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bil_pkg::dp_stat_t stat,
  output bil_pkg::dp_cmd_t  cmd
);

  bil_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bil_pkg::S_IDLE: begin
        if (req_valid) state_next = bil_pkg::S_DECIDE;
      end
      bil_pkg::S_DECIDE: begin
        unique case (stat.op)
          bil_pkg::OP_INSERT: state_next = stat.ins_ok ? bil_pkg::S_WALK : bil_pkg::S_FINISH;
          bil_pkg::OP_REMOVE: state_next = stat.rem_ok ? bil_pkg::S_WALK : bil_pkg::S_FINISH;
          bil_pkg::OP_SEARCH: state_next = bil_pkg::S_WALK;
          bil_pkg::OP_READ:   state_next = stat.rd_ok ? bil_pkg::S_RDWAIT : bil_pkg::S_FINISH;
          default:            state_next = bil_pkg::S_FINISH;
        endcase
      end
      bil_pkg::S_WALK: begin
        if (stat.walk_done) begin
          state_next = (stat.op == bil_pkg::OP_INSERT) ? bil_pkg::S_PUT : bil_pkg::S_FINISH;
        end
      end
      bil_pkg::S_PUT:    state_next = bil_pkg::S_FINISH;
      bil_pkg::S_RDWAIT: state_next = bil_pkg::S_FINISH;
      bil_pkg::S_FINISH: begin
        if (stat.out_free) state_next = bil_pkg::S_IDLE;
      end
      default: state_next = bil_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      bil_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      bil_pkg::S_DECIDE: begin
        unique case (stat.op)
          bil_pkg::OP_INSERT:  cmd.walk_start = stat.ins_ok;
          bil_pkg::OP_REMOVE:  cmd.walk_start = stat.rem_ok;
          bil_pkg::OP_SEARCH:  cmd.walk_start = 1'b1;
          bil_pkg::OP_READ:    cmd.read_issue = stat.rd_ok;
          bil_pkg::OP_REPLACE: cmd.write_val  = stat.rep_ok;
          default: ;
        endcase
      end
      bil_pkg::S_WALK:   cmd.walk_step    = 1'b1;
      bil_pkg::S_PUT:    cmd.write_val    = 1'b1;
      bil_pkg::S_RDWAIT: cmd.read_capture = 1'b1;
      bil_pkg::S_FINISH: cmd.finish       = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/bil_dpath.sv =====
// Datapath of the bounded indexed list: request registers, count, walk pointer,
// entry memory and response register. Depends on bil_pkg and bil_ram.
`timescale 1ns / 1ps

module bil_dpath #(
  parameter int DEPTH       = bil_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = bil_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bil_pkg::dp_cmd_t                   cmd,
  output bil_pkg::dp_stat_t                  stat,
  input  logic [bil_pkg::OP_W-1:0]           req_op,
  input  logic [bil_pkg::POS_W-1:0]          req_position,
  input  logic signed [bil_pkg::ITEM_W-1:0]  req_item_value,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               rsp_ok,
  output logic signed [bil_pkg::ITEM_W-1:0]  rsp_read_data,
  output logic [bil_pkg::POS_W-1:0]          rsp_found_position,
  output logic [bil_pkg::POS_W-1:0]          rsp_entry_count,
  output logic                               rsp_is_empty,
  output logic                               rsp_is_full
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bil_pkg::POS_W) ? CW : bil_pkg::POS_W;

  bil_pkg::op_t           op_r;
  logic [CMPW-1:0]        pos_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          count, count_next;
  logic [AW-1:0]          ptr;
  logic [CW-1:0]          remaining;
  logic                   rd_vld;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic [CW-1:0]          found_r;

  logic [CMPW-1:0]        cnt_ext;
  logic [AW-1:0]          pos_a, last_a, read_a;
  logic                   ins_ok, rem_ok, rd_ok, ok_now, match;
  logic [63:0]            val_wide, rd_wide;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  assign cnt_ext  = CMPW'(count);
  assign pos_a    = AW'(pos_r);
  assign last_a   = AW'(count - CW'(1));
  assign read_a   = (pos_r < cnt_ext) ? pos_a : last_a;
  assign ins_ok   = (count != CW'(DEPTH)) && (pos_r <= cnt_ext);
  assign rem_ok   = pos_r < cnt_ext;
  assign rd_ok    = count != '0;
  assign match    = rd_vld && (op_r == bil_pkg::OP_SEARCH) && (ram_rdata == val_r);
  assign val_wide = 64'(signed'(req_item_value));
  assign rd_wide  = 64'(rdata_r);

  always_comb begin
    ok_now = 1'b0;
    unique case (op_r)
      bil_pkg::OP_INSERT:  ok_now = ins_ok;
      bil_pkg::OP_REMOVE:  ok_now = rem_ok;
      bil_pkg::OP_READ:    ok_now = rd_ok;
      bil_pkg::OP_SEARCH:  ok_now = 1'b1;
      bil_pkg::OP_REPLACE: ok_now = rem_ok;
      default:             ok_now = 1'b0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ok_now && op_r == bil_pkg::OP_INSERT) begin
      count_next = count + CW'(1);
    end else if (ok_now && op_r == bil_pkg::OP_REMOVE) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.ins_ok    = ins_ok;
    stat.rem_ok    = rem_ok;
    stat.rd_ok     = rd_ok;
    stat.rep_ok    = rem_ok;
    stat.walk_done = ((remaining == '0) && !rd_vld) || match;
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_comb begin
    ram_raddr = cmd.read_issue ? read_a : ptr;
    ram_we    = cmd.write_val || (cmd.walk_step && rd_vld &&
                (op_r == bil_pkg::OP_INSERT || op_r == bil_pkg::OP_REMOVE));
    ram_wdata = cmd.write_val ? val_r : ram_rdata;
    if (cmd.write_val) begin
      ram_waddr = pos_a;
    end else if (op_r == bil_pkg::OP_INSERT) begin
      ram_waddr = rd_addr + AW'(1);
    end else begin
      ram_waddr = rd_addr - AW'(1);
    end
  end

  bil_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_bil_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= bil_pkg::op_t'(req_op);
      pos_r <= CMPW'(req_position);
      val_r <= val_wide[VALUE_WIDTH-1:0];
    end
    if (cmd.walk_start) begin
      priority case (op_r)
        bil_pkg::OP_INSERT: ptr <= last_a;
        bil_pkg::OP_REMOVE: ptr <= pos_a + AW'(1);
        default:            ptr <= '0;
      endcase
      found_r <= count;
    end else if (cmd.walk_step && remaining != '0) begin
      ptr <= (op_r == bil_pkg::OP_INSERT) ? ptr - AW'(1) : ptr + AW'(1);
    end
    if (cmd.walk_step && match) begin
      found_r <= CW'(rd_addr);
    end
    rd_addr <= ptr;
    if (cmd.read_capture) begin
      rdata_r <= ram_rdata;
    end
    if (cmd.finish) begin
      rsp_ok             <= ok_now;
      rsp_read_data      <= (op_r == bil_pkg::OP_READ && rd_ok) ? rd_wide[31:0] : '0;
      rsp_found_position <= (op_r == bil_pkg::OP_SEARCH) ? bil_pkg::POS_W'(found_r) : '0;
      rsp_entry_count    <= bil_pkg::POS_W'(count_next);
      rsp_is_empty       <= count_next == '0;
      rsp_is_full        <= count_next == CW'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.read_issue || (cmd.walk_step && remaining != '0);
      if (cmd.walk_start) begin
        priority case (op_r)
          bil_pkg::OP_INSERT: remaining <= count - CW'(pos_r);
          bil_pkg::OP_REMOVE: remaining <= count - CW'(pos_r) - CW'(1);
          default:            remaining <= count;
        endcase
      end else if (cmd.walk_step && remaining != '0) begin
        remaining <= remaining - CW'(1);
      end
      if (cmd.finish) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/bounded_indexed_list.sv =====
// Top level of the bounded indexed list: controller, datapath and channels.
// Depends on bil_pkg, bil_req_if, bil_rsp_if, bil_ctrl and bil_dpath.
`timescale 1ns / 1ps

// An ordered list of up to DEPTH values in one simple dual-port memory, with an
// entry count; one request at a time. Each request runs IDLE, DECIDE, FINISH; a
// successful read adds RDWAIT, a successful insert or remove and any search add
// WALK, an insert then PUT. The walk moves count - position entries for insert,
// count - position - 1 for remove and up to count for search; insert, remove and
// search move or scan one entry a cycle through the memory's single read port and
// single write port. The next request is accepted the cycle after the response is
// loaded, while that response may still wait to be taken. Entries hold no reset
// value; only positions below the count are ever read.
module bounded_indexed_list #(
  parameter int DEPTH       = bil_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = bil_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  bil_req_if.sink    req,
  bil_rsp_if.source  rsp
);

  bil_pkg::dp_cmd_t  cmd;
  bil_pkg::dp_stat_t stat;

  bil_ctrl u_bil_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bil_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bil_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .req_op             (req.op),
    .req_position       (req.position),
    .req_item_value     (req.item_value),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_read_data      (rsp.read_data),
    .rsp_found_position (rsp.found_position),
    .rsp_entry_count    (rsp.entry_count),
    .rsp_is_empty       (rsp.is_empty),
    .rsp_is_full        (rsp.is_full)
  );

endmodule

// ===== rtl/bil_checker.sv =====
// Port-level checks for the bounded indexed list, bound to the top level.
// Depends on bounded_indexed_list.
`timescale 1ns / 1ps

module bil_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [31:0] rsp_read_data,
  input logic [6:0]  rsp_found_position,
  input logic        rsp_is_empty,
  input logic        rsp_is_full
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_ok))
    else $error("response dropped or changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new request taken while one is in progress");

  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_is_empty && rsp_is_full))
    else $error("list reported empty and full at once");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_read_data == '0 && rsp_found_position == '0)
    else $error("failed request returned data");

endmodule

bind bounded_indexed_list bil_checker u_bil_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ok             (rsp.ok),
  .rsp_read_data      (rsp.read_data),
  .rsp_found_position (rsp.found_position),
  .rsp_is_empty       (rsp.is_empty),
  .rsp_is_full        (rsp.is_full)
);

// ===== dv/bounded_indexed_list_tb.sv =====
// Testbench for bounded_indexed_list: a directed table, then randomized request mixes,
// each response checked against its table row or a bench-kept shadow of the list.
// Depends on bil_pkg, bil_req_if, bil_rsp_if and the bounded_indexed_list RTL.
`timescale 1ns / 1ps

module bounded_indexed_list_tb;

  localparam int LIST_DEPTH = bil_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1800;
  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_data;
    logic [6:0]  found_position;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } list_result_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [6:0]   position;
    logic [31:0]  item_value;
    logic         typed;
    list_result_t result;
  } list_request_t;

  logic clk = 1'b0;
  logic rst;

  bil_req_if req ();
  bil_rsp_if rsp ();

  bounded_indexed_list DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("bounded_indexed_list_tb failed");
    $finish;
  end

  logic [31:0]   shadow_entries [LIST_DEPTH];
  int            shadow_count = 0;
  list_result_t  pending_results [$];
  list_request_t directed_rows [$];
  int            mismatch_count = 0;
  int            responses_seen = 0;
  int            hold_left = 0;

  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] position,
                                                 logic [31:0] value);
    list_result_t r;
    int p;
    int slot;
    r = '0;
    p = int'(position);
    case (op)
      bil_pkg::OP_INSERT: begin
        if (shadow_count < LIST_DEPTH && p <= shadow_count) begin
          for (slot = shadow_count; slot > p; slot--)
            shadow_entries[slot] = shadow_entries[slot - 1];
          shadow_entries[p] = value;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      bil_pkg::OP_REMOVE: begin
        if (p < shadow_count) begin
          for (slot = p; slot + 1 < shadow_count; slot++)
            shadow_entries[slot] = shadow_entries[slot + 1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      bil_pkg::OP_READ: begin
        if (shadow_count > 0) begin
          r.read_data = shadow_entries[(p < shadow_count) ? p : shadow_count - 1];
          r.ok = 1'b1;
        end
      end
      bil_pkg::OP_SEARCH: begin
        r.found_position = 7'(shadow_count);
        for (slot = shadow_count - 1; slot >= 0; slot--)
          if (shadow_entries[slot] == value) r.found_position = 7'(slot);
        r.ok = 1'b1;
      end
      bil_pkg::OP_REPLACE: begin
        if (p < shadow_count) begin
          shadow_entries[p] = value;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 7'(shadow_count);
    r.is_empty = (shadow_count == 0);
    r.is_full = (shadow_count == LIST_DEPTH);
    return r;
  endfunction

  function automatic list_request_t row(logic [2:0] op, int pos, logic [31:0] value,
                                        bit typed, bit ok, logic [31:0] data,
                                        int found, int cnt);
    list_request_t rq;
    rq.op = op;
    rq.position = 7'(pos);
    rq.item_value = value;
    rq.typed = typed;
    rq.result.ok = ok;
    rq.result.read_data = data;
    rq.result.found_position = 7'(found);
    rq.result.entry_count = 7'(cnt);
    rq.result.is_empty = (cnt == 0);
    rq.result.is_full = (cnt == LIST_DEPTH);
    return rq;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 15)) - 32'd8;
    if (r < 7) return $urandom;
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_NEG1;
        default: return 32'd0;
      endcase
    end
    if (shadow_count > 0) return shadow_entries[$urandom_range(0, shadow_count - 1)];
    return $urandom;
  endfunction

  // mix: 0 grows the list, 1 drains it, 2 grows it slowly
  function automatic list_request_t make_request(int mix);
    list_request_t rq;
    int r;
    int ins_lim;
    int rem_lim;
    int rd_lim;
    int srch_lim;
    int rep_lim;
    rq = '0;
    case (mix)
      0: begin
        ins_lim = 65; rem_lim = 75; rd_lim = 83; srch_lim = 91; rep_lim = 97;
      end
      1: begin
        ins_lim = 15; rem_lim = 70; rd_lim = 80; srch_lim = 88; rep_lim = 97;
      end
      default: begin
        ins_lim = 30; rem_lim = 50; rd_lim = 65; srch_lim = 80; rep_lim = 97;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_lim) rq.op = bil_pkg::OP_INSERT;
    else if (r < rem_lim) rq.op = bil_pkg::OP_REMOVE;
    else if (r < rd_lim) rq.op = bil_pkg::OP_READ;
    else if (r < srch_lim) rq.op = bil_pkg::OP_SEARCH;
    else if (r < rep_lim) rq.op = bil_pkg::OP_REPLACE;
    else rq.op = 3'($urandom_range(OP_SPARE0, OP_SPARE2));

    if ($urandom_range(0, 9) == 0) begin
      rq.position = 7'($urandom_range(0, 127));
    end else if (rq.op == bil_pkg::OP_INSERT) begin
      case ($urandom_range(0, 4))
        0: rq.position = 7'd0;
        1: rq.position = 7'(shadow_count);
        default: rq.position = 7'($urandom_range(0, shadow_count));
      endcase
    end else if (shadow_count == 0) begin
      rq.position = 7'd0;
    end else begin
      case ($urandom_range(0, 4))
        0: rq.position = 7'd0;
        1: rq.position = 7'(shadow_count - 1);
        default: rq.position = 7'($urandom_range(0, shadow_count - 1));
      endcase
    end
    rq.item_value = pick_value();
    return rq;
  endfunction

  task automatic send_request(list_request_t rq, int idle_pct);
    list_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= rq.op;
    req.position <= rq.position;
    req.item_value <= rq.item_value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = apply_list_op(rq.op, rq.position, rq.item_value);
    pending_results.push_back(rq.typed ? rq.result : predicted);
  endtask

  task automatic drain_pending();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_response();
    list_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: response with no request pending, expected none, actual count %0d",
               $time, rsp.entry_count);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("ok", 32'(want.ok), 32'(rsp.ok));
      compare_field("read_data", want.read_data, rsp.read_data);
      compare_field("found_position", 32'(want.found_position), 32'(rsp.found_position));
      compare_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
      compare_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        check_response();
        responses_seen++;
        if (responses_seen == 400) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (responses_seen >= 1200 && responses_seen < 1500) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin
    int n;
    int mix;
    int idle_pct;
    int waited;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.op <= bil_pkg::OP_INSERT;
    req.position <= '0;
    req.item_value <= '0;

    directed_rows.push_back(row(bil_pkg::OP_READ, 0, 32'd0, 1, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_REMOVE, 0, 32'd0, 1, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_REPLACE, 0, 32'd5, 1, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_SEARCH, 0, 32'd7, 1, 1, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 1, 32'd9, 1, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 0, VAL_MAX, 1, 1, 32'd0, 0, 1));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 0, VAL_MIN, 1, 1, 32'd0, 0, 2));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 2, VAL_NEG1, 1, 1, 32'd0, 0, 3));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 1, 32'd0, 0, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_READ, 0, 32'd0, 1, 1, VAL_MIN, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_READ, 127, 32'd0, 1, 1, VAL_NEG1, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_READ, 4, 32'd0, 1, 1, VAL_NEG1, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_SEARCH, 0, VAL_MAX, 0, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_SEARCH, 0, 32'd12345, 1, 1, 32'd0, 4, 4));
    directed_rows.push_back(row(bil_pkg::OP_REPLACE, 2, 32'h5555_5555, 0, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_REPLACE, 4, 32'd1, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_REMOVE, 4, 32'd0, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_REMOVE, 64, 32'd0, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_INSERT, 64, 32'd1, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(OP_SPARE0, 0, 32'd0, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(OP_SPARE1, 127, VAL_NEG1, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(OP_SPARE2, 3, 32'd0, 1, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(bil_pkg::OP_REMOVE, 0, 32'd0, 0, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_SEARCH, 0, 32'd0, 0, 0, 32'd0, 0, 0));
    directed_rows.push_back(row(bil_pkg::OP_REMOVE, 2, 32'd0, 0, 0, 32'd0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i], 33);
    drain_pending();

    mix = 0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 120 == 0 && n != 0) mix = $urandom_range(0, 2);
      if (n == 1000) drain_pending();
      idle_pct = (n >= 600 && n < 900) ? 0 : 33;
      send_request(make_request(mix), idle_pct);
    end
    req.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d responses missing, expected 0 pending, actual %0d", $time,
               pending_results.size(), pending_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("bounded_indexed_list_tb passed");
    end else begin
      $display("bounded_indexed_list_tb failed");
    end
    $finish;
  end

endmodule
